// ===== design/cfa_pkg.sv =====
package cfa_pkg;

    localparam int unsigned MEM_BYTES_DEF    = 1048576;
    localparam int unsigned MAX_SEGMENTS_DEF = 256;

    localparam int unsigned SIZE_W  = 21;
    localparam int unsigned ADDR_W  = 20;
    localparam int unsigned CNT_W   = 9;

    typedef enum logic [1:0] {
        RC_OK       = 2'd0,
        RC_NOFIT    = 2'd1,
        RC_NOTFOUND = 2'd2,
        RC_FULL     = 2'd3
    } rc_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_SPARE = 2'd3
    } fit_t;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // one request as classified by the front end
    typedef struct packed {
        logic              is_release;
        logic              zero_size;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    // one result handed back by the table engine
    typedef struct packed {
        rc_t               code;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] bytes;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  holes;
    } res_t;

endpackage

// ===== design/contiguous_fit_allocator.sv =====
// Each request sweeps the table of N segments; a split or merge also moves entries
//   in the table memory, which has one read port and one write port.
// Throughput: one request at a time; the sequencer's table sweeps set the rate.
// Reset: asynchronous, active low; the table restarts as one hole over the region
//   after a one-cycle initialisation write, and fit_mode returns to first fit.
module contiguous_fit_allocator
#(
    parameter int unsigned MEM_BYTES    = cfa_pkg::MEM_BYTES_DEF,
    parameter int unsigned MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [cfa_pkg::SIZE_W-1:0]  req_size,
    input  logic [cfa_pkg::ADDR_W-1:0]  release_addr,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  result_code,
    output logic [cfa_pkg::ADDR_W-1:0]  alloc_start,
    output logic [cfa_pkg::SIZE_W-1:0]  bytes_in_use,
    output logic [cfa_pkg::CNT_W-1:0]   used_count,
    output logic [cfa_pkg::CNT_W-1:0]   hole_total
);

    logic [1:0]    fit_mode_reg;
    logic          q_valid, q_ready;
    cfa_pkg::cmd_t q_cmd;
    cfa_pkg::res_t res;

    // hold the fit mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= cfa_pkg::FIT_FIRST;
        end
        else if (cfg_we)
        begin
            fit_mode_reg <= cfg_wdata;
        end
    end

    cfa_front u_front
    (
        .clk, .rst_n, .in_valid, .in_ready, .opcode, .req_size, .release_addr,
        .q_valid, .q_ready, .q_cmd
    );

    cfa_engine #(.MEM_BYTES(MEM_BYTES), .MAX_SEGMENTS(MAX_SEGMENTS)) u_engine
    (
        .clk, .rst_n, .fit_mode(fit_mode_reg), .q_valid, .q_ready, .q_cmd,
        .out_valid, .out_ready, .res
    );

    assign result_code  = res.code;
    assign alloc_start  = res.start;
    assign bytes_in_use = res.bytes;
    assign used_count   = res.used;
    assign hole_total   = res.holes;

    // a failed request grants no start
    a_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code != cfa_pkg::RC_OK |-> alloc_start == '0)
        else $error("start given on failed request");

    // a pending result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_code))
        else $error("result dropped");

endmodule

// ===== design/cfa_front.sv =====
module cfa_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [cfa_pkg::SIZE_W-1:0]  req_size,
    input  logic [cfa_pkg::ADDR_W-1:0]  release_addr,
    output logic                        q_valid,
    input  logic                        q_ready,
    output cfa_pkg::cmd_t               q_cmd
);

    // two-entry queue of classified requests
    cfa_pkg::cmd_t mem_reg [2];
    logic          wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    cfa_pkg::cmd_t cmd;
    logic          push, pop;

    always_comb
    begin
        cmd.is_release = (opcode == cfa_pkg::OP_RELEASE);
        cmd.zero_size  = (req_size == '0);
        cmd.size       = req_size;
        cmd.addr       = release_addr;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // store the request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= cmd;
        end
    end

endmodule

// ===== design/cfa_engine.sv =====
module cfa_engine
#(
    parameter int unsigned MEM_BYTES    = cfa_pkg::MEM_BYTES_DEF,
    parameter int unsigned MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         fit_mode,
    input  logic               q_valid,
    output logic               q_ready,
    input  cfa_pkg::cmd_t      q_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output cfa_pkg::res_t      res
);

    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned SW = cfa_pkg::SIZE_W;
    localparam int unsigned AW = cfa_pkg::ADDR_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
    localparam logic [SW-1:0] MEMSZ = SW'(MEM_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_RD, S_DEC, S_SHUP, S_SPLIT,
        S_REL, S_SHDN, S_STAT, S_OUT
    } st_t;

    // table memory: start, size, used packed in one word
    localparam int unsigned EW = AW + SW + 1;
    logic [EW-1:0] tab [MAX_SEGMENTS];
    logic [EW-1:0] rd_reg;
    logic [IW-1:0] ra;
    logic          we;
    logic [IW-1:0] wa;
    logic [EW-1:0] wd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tab[wa] <= wd;
        end
        rd_reg <= tab[ra];
    end

    st_t            st_reg;
    cfa_pkg::cmd_t  cmd_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  i_reg;
    logic           rdv_reg;
    logic           found_reg;
    logic [IW-1:0]  pick_reg;
    logic [SW-1:0]  psize_reg;
    logic [AW-1:0]  pstart_reg;
    logic [IW-1:0]  k_reg;
    logic [1:0]     mode_reg;
    logic           merge_prev_reg;
    logic [SW-1:0]  nsize_reg;
    logic [IW-1:0]  hole_reg;
    logic [1:0]     drops_reg;
    logic [IW-1:0]  dpos_reg;
    logic [SW-1:0]  bytes_reg;
    logic [CW-1:0]  used_reg, holes_reg;
    cfa_pkg::rc_t   code_reg;
    logic [AW-1:0]  start_reg;
    logic           out_valid_reg;
    cfa_pkg::res_t  res_reg;
    logic [SW-1:0]  prev_size_reg;
    logic           prev_used_reg;
    logic           rsi_reg;

    logic [AW-1:0]  e_start;
    logic [SW-1:0]  e_size;
    logic           e_used;

    assign e_start = rd_reg[EW-1 -: AW];
    assign e_size  = rd_reg[SW:1];
    assign e_used  = rd_reg[0];

    assign q_ready   = (st_reg == S_IDLE) && !out_valid_reg && !rsi_reg;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // memory port addressing per state
    always_comb
    begin
        ra = i_reg[IW-1:0];
        we = 1'b0;
        wa = '0;
        wd = '0;
        unique case (st_reg)
            S_IDLE:
            begin
                // reset write of entry zero: one hole over the whole region
                if (rsi_reg)
                begin
                    we = 1'b1;
                    wa = '0;
                    wd = {AW'(0), MEMSZ, 1'b0};
                end
            end
            S_REL:
            begin
                ra = pick_reg + IW'(1);
            end
            S_SHUP:
            begin
                ra = k_reg - IW'(1);
                if (rdv_reg)
                begin
                    we = 1'b1;
                    wa = k_reg;
                    wd = rd_reg;
                end
            end
            S_SPLIT:
            begin
                we = 1'b1;
                wa = pick_reg + IW'(1);
                wd = {pstart_reg + cmd_reg.size[AW-1:0], psize_reg - cmd_reg.size, 1'b0};
            end
            S_SHDN:
            begin
                ra = k_reg + IW'(drops_reg);
                if (rdv_reg)
                begin
                    we = 1'b1;
                    wa = k_reg;
                    wd = rd_reg;
                end
            end
            S_DEC:
            begin
                we = 1'b1;
                wa = hole_reg;
                wd = cmd_reg.is_release ? {pstart_reg, nsize_reg, 1'b0}
                                        : {pstart_reg, cmd_reg.size, 1'b1};
            end
            default: ;
        endcase
    end

    logic fits;
    assign fits = !e_used && (e_size >= cmd_reg.size);

    // single sequencer over the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            cnt_reg       <= CW'(1);
            out_valid_reg <= 1'b0;
            rdv_reg       <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            drops_reg     <= '0;
            rsi_reg       <= 1'b1;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (rsi_reg)
                    begin
                        // reset entry zero to one whole hole
                        rsi_reg <= 1'b0;
                    end
                    else if (q_valid && q_ready)
                    begin
                        cmd_reg   <= q_cmd;
                        mode_reg  <= fit_mode;
                        i_reg     <= '0;
                        rdv_reg   <= 1'b0;
                        found_reg <= 1'b0;
                        prev_used_reg <= 1'b1;
                        start_reg <= '0;
                        if (!q_cmd.is_release && q_cmd.zero_size)
                        begin
                            code_reg <= cfa_pkg::RC_NOFIT;
                            st_reg   <= S_STAT;
                        end
                        else
                        begin
                            st_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // one entry a cycle, read data arrives the cycle after its address
                    if (!rdv_reg)
                    begin
                        rdv_reg <= 1'b1;
                        i_reg   <= i_reg + CW'(1);
                    end
                    else if (cmd_reg.is_release && e_start == cmd_reg.addr)
                    begin
                        found_reg <= 1'b1;
                        pick_reg  <= IW'(i_reg - CW'(1));
                        st_reg    <= S_REL;
                        merge_prev_reg <= (i_reg != CW'(1)) && !prev_used_reg;
                        psize_reg <= e_size;
                        pstart_reg <= e_start;
                        code_reg  <= e_used ? cfa_pkg::RC_OK
                                            : cfa_pkg::RC_NOTFOUND;
                        rdv_reg   <= 1'b0;
                    end
                    else
                    begin
                        if (cmd_reg.is_release)
                        begin
                            prev_used_reg <= e_used;
                            prev_size_reg <= e_size;
                        end
                        else if (fits)
                        begin
                            if (!found_reg
                                || (mode_reg == cfa_pkg::FIT_BEST && e_size < psize_reg)
                                || (mode_reg == cfa_pkg::FIT_WORST && e_size > psize_reg))
                            begin
                                pick_reg   <= IW'(i_reg - CW'(1));
                                psize_reg  <= e_size;
                                pstart_reg <= e_start;
                            end
                            found_reg <= 1'b1;
                        end
                        if (i_reg == cnt_reg
                            || (!cmd_reg.is_release && fits && !found_reg
                                && mode_reg != cfa_pkg::FIT_BEST
                                && mode_reg != cfa_pkg::FIT_WORST))
                        begin
                            st_reg <= S_RD;
                        end
                        else
                        begin
                            i_reg <= i_reg + CW'(1);
                        end
                    end
                end
                S_RD:
                begin
                    // scan over: decide the allocate, or report a release not found
                    if (cmd_reg.is_release)
                    begin
                        code_reg <= cfa_pkg::RC_NOTFOUND;
                        st_reg   <= S_STAT;
                    end
                    else if (!found_reg)
                    begin
                        code_reg <= cfa_pkg::RC_NOFIT;
                        st_reg   <= S_STAT;
                    end
                    else if (psize_reg > cmd_reg.size && cnt_reg >= MAXC)
                    begin
                        code_reg <= cfa_pkg::RC_FULL;
                        st_reg   <= S_STAT;
                    end
                    else
                    begin
                        code_reg  <= cfa_pkg::RC_OK;
                        start_reg <= pstart_reg;
                        hole_reg  <= pick_reg;
                        if (psize_reg > cmd_reg.size)
                        begin
                            k_reg   <= IW'(cnt_reg);
                            cnt_reg <= cnt_reg + CW'(1);
                            rdv_reg <= 1'b0;
                            st_reg  <= S_SHUP;
                        end
                        else
                        begin
                            st_reg <= S_DEC;
                        end
                    end
                end
                S_SHUP:
                begin
                    // move entries up one place, top down
                    if (k_reg == pick_reg + IW'(1))
                    begin
                        st_reg <= S_SPLIT;
                    end
                    else if (!rdv_reg)
                    begin
                        rdv_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg   <= k_reg - IW'(1);
                        rdv_reg <= 1'b0;
                    end
                end
                S_SPLIT:
                begin
                    st_reg <= S_DEC;
                end
                S_REL:
                begin
                    // look at the next neighbour
                    if (code_reg != cfa_pkg::RC_OK)
                    begin
                        st_reg <= S_STAT;
                    end
                    else if (!rdv_reg)
                    begin
                        rdv_reg <= 1'b1;
                    end
                    else
                    begin
                        nsize_reg <= psize_reg
                            + ((({1'b0, pick_reg} + CW'(1) < cnt_reg) && !e_used)
                               ? e_size : '0)
                            + (merge_prev_reg ? prev_size_reg : '0);
                        hole_reg  <= merge_prev_reg ? pick_reg - IW'(1) : pick_reg;
                        pstart_reg <= merge_prev_reg ? pstart_reg - prev_size_reg[AW-1:0]
                                                     : pstart_reg;
                        drops_reg <= {1'b0, merge_prev_reg}
                            + {1'b0, (({1'b0, pick_reg} + CW'(1) < cnt_reg) && !e_used)};
                        dpos_reg  <= merge_prev_reg ? pick_reg : pick_reg + IW'(1);
                        st_reg    <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    if (cmd_reg.is_release && drops_reg != '0)
                    begin
                        k_reg   <= dpos_reg;
                        rdv_reg <= 1'b0;
                        st_reg  <= S_SHDN;
                    end
                    else
                    begin
                        st_reg <= S_STAT;
                        i_reg  <= '0;
                        rdv_reg <= 1'b0;
                        bytes_reg <= '0;
                        used_reg  <= '0;
                        holes_reg <= '0;
                    end
                end
                S_SHDN:
                begin
                    // drop merged entries by moving later ones down
                    if ({1'b0, k_reg} + CW'(drops_reg) >= cnt_reg)
                    begin
                        cnt_reg <= cnt_reg - CW'(drops_reg);
                        st_reg  <= S_STAT;
                    end
                    else if (!rdv_reg)
                    begin
                        rdv_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg   <= k_reg + IW'(1);
                        rdv_reg <= 1'b0;
                    end
                end
                S_STAT:
                begin
                    st_reg    <= S_OUT;
                    i_reg     <= '0;
                    rdv_reg   <= 1'b0;
                    bytes_reg <= '0;
                    used_reg  <= '0;
                    holes_reg <= '0;
                end
                S_OUT:
                begin
                    // sum the table, one entry a cycle
                    rdv_reg <= 1'b1;
                    if (rdv_reg)
                    begin
                        if (e_used)
                        begin
                            bytes_reg <= bytes_reg + e_size;
                            used_reg  <= used_reg + CW'(1);
                        end
                        else
                        begin
                            holes_reg <= holes_reg + CW'(1);
                        end
                    end
                    if (i_reg == cnt_reg && rdv_reg)
                    begin
                        st_reg <= S_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                    else if (i_reg != cnt_reg)
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (st_reg == S_OUT && i_reg == cnt_reg && rdv_reg)
        begin
            res_reg.code  <= code_reg;
            res_reg.start <= start_reg;
            res_reg.bytes <= e_used ? bytes_reg + e_size : bytes_reg;
            res_reg.used  <= cfa_pkg::CNT_W'(e_used ? used_reg + CW'(1) : used_reg);
            res_reg.holes <= cfa_pkg::CNT_W'(e_used ? holes_reg : holes_reg + CW'(1));
        end
    end

endmodule
